// File: rtl/bspe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspe_pkg
// Shared constants, operation codes and controller/datapath structs for the
// cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
package bspe_pkg;

    localparam int MAX_POINTS = 16;
    localparam int DEGREE     = 3;
    localparam int KNOT_DEPTH = MAX_POINTS + DEGREE + 1;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 5;
    localparam int KNOT_W  = 17;
    localparam int PT_W    = 16;
    localparam int CFG_W   = 5;
    localparam int SPAN_W  = 4;
    localparam int OUT_W   = 24;
    localparam int NB_W    = 32;
    localparam int DIFF_W  = KNOT_W + 1;
    localparam int DEN_W   = KNOT_W + 2;
    localparam int DVD_W   = NB_W + 16;
    localparam int QUO_W   = DVD_W + 1;
    localparam int TEMP_W  = 46;

    localparam logic [MODE_W-1:0] MODE_KNOT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL  = 2'd2;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE      = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_SPAN_END  = 5'd2;
    localparam op_t OP_SPAN_SCAN = 5'd3;
    localparam op_t OP_INIT      = 5'd4;
    localparam op_t OP_LEFT      = 5'd5;
    localparam op_t OP_RIGHT     = 5'd6;
    localparam op_t OP_DIV_GO    = 5'd7;
    localparam op_t OP_RMH       = 5'd8;
    localparam op_t OP_RML       = 5'd9;
    localparam op_t OP_RFIN      = 5'd10;
    localparam op_t OP_LMH       = 5'd11;
    localparam op_t OP_LML       = 5'd12;
    localparam op_t OP_LFIN      = 5'd13;
    localparam op_t OP_NBJ       = 5'd14;
    localparam op_t OP_PT_MUL    = 5'd15;
    localparam op_t OP_PT_ACC    = 5'd16;
    localparam op_t OP_FINISH    = 5'd17;

    typedef struct packed {
        op_t                op;
        logic [1:0]         j;
        logic [1:0]         r;
        logic [SPAN_W-1:0]  k;
    } dp_cmd_t;

    typedef struct packed {
        logic               u_ge_knot;
        logic               den_zero;
        logic               div_done;
        logic               out_free;
        logic [SPAN_W-1:0]  n_last;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/bspe_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspe_div
// Sequential signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module bspe_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [bspe_pkg::DVD_W-1:0]    dividend,
    input  wire logic signed [bspe_pkg::DEN_W-1:0]    divisor,
    output logic                                      done,
    output logic signed [bspe_pkg::QUO_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(bspe_pkg::DVD_W + 1);

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [bspe_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [bspe_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [bspe_pkg::DEN_W-1:0] dvs_reg, dvs_next;
    logic                       neg_reg, neg_next;
    logic [bspe_pkg::DEN_W+1:0] trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        trial     = {1'b0, rem_reg, quo_reg[bspe_pkg::DVD_W-1]} - {2'b00, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(bspe_pkg::DVD_W);
            rem_next  = '0;
            quo_next  = dividend[bspe_pkg::DVD_W-1] ? bspe_pkg::DVD_W'(-dividend)
                                                    : bspe_pkg::DVD_W'(dividend);
            dvs_next  = divisor[bspe_pkg::DEN_W-1] ? bspe_pkg::DEN_W'(-divisor)
                                                   : bspe_pkg::DEN_W'(divisor);
            neg_next  = dividend[bspe_pkg::DVD_W-1] ^ divisor[bspe_pkg::DEN_W-1];
        end else if (busy_reg) begin
            if (trial[bspe_pkg::DEN_W+1]) begin
                rem_next = {rem_reg[bspe_pkg::DEN_W-2:0], quo_reg[bspe_pkg::DVD_W-1]};
                quo_next = {quo_reg[bspe_pkg::DVD_W-2:0], 1'b0};
            end else begin
                rem_next = trial[bspe_pkg::DEN_W-1:0];
                quo_next = {quo_reg[bspe_pkg::DVD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule
`default_nettype wire

// File: rtl/bspe_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspe_dpath
// Knot and point stores, span search compare, Cox-de Boor basis arithmetic,
// weighted point sum and the output register.
// ----------------------------------------------------------------------------
module bspe_dpath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire bspe_pkg::dp_cmd_t                   cmd,
    output bspe_pkg::dp_stat_t                       stat,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bspe_pkg::CFG_W-1:0]          cfg_wr_data,
    input  wire logic [bspe_pkg::MODE_W-1:0]         in_mode,
    input  wire logic [bspe_pkg::IDX_W-1:0]          in_index,
    input  wire logic [bspe_pkg::KNOT_W-1:0]         in_knot_value,
    input  wire logic [bspe_pkg::PT_W-1:0]           in_point_x,
    input  wire logic [bspe_pkg::PT_W-1:0]           in_point_y,
    input  wire logic [bspe_pkg::KNOT_W-1:0]         in_param_u,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [bspe_pkg::OUT_W-1:0]               out_curve_x,
    output logic [bspe_pkg::OUT_W-1:0]               out_curve_y,
    output logic [bspe_pkg::SPAN_W-1:0]              out_span,
    output logic                                     out_status
);

    localparam int MH_W   = 23;
    localparam int TEMP_LO_W = bspe_pkg::TEMP_W - MH_W;
    localparam int ML_W   = TEMP_LO_W + 1;
    localparam int PROD_W = bspe_pkg::DIFF_W + ML_W;
    localparam int FULL_W = 66;
    localparam int SAV_W  = 48;
    localparam int PP_W   = bspe_pkg::NB_W + bspe_pkg::PT_W;
    localparam int ACC_W  = PP_W + 2;

    localparam logic signed [bspe_pkg::QUO_W-1:0] TEMP_MAX =
        bspe_pkg::QUO_W'((64'sd1 <<< (bspe_pkg::TEMP_W - 1)) - 64'sd1);
    localparam logic signed [bspe_pkg::QUO_W-1:0] TEMP_MIN =
        bspe_pkg::QUO_W'(-(64'sd1 <<< (bspe_pkg::TEMP_W - 1)));

    function automatic logic signed [FULL_W-1:0] trunc16(input logic signed [FULL_W-1:0] v);
        logic signed [FULL_W-1:0] t;
        t = v[FULL_W-1] ? v + FULL_W'(65535) : v;
        return t >>> 16;
    endfunction

    function automatic logic signed [bspe_pkg::NB_W-1:0] sat32(
        input logic signed [FULL_W-1:0] v);
        logic signed [FULL_W-1:0] hi;
        logic signed [FULL_W-1:0] lo;
        hi = FULL_W'(64'sd2147483647);
        lo = -FULL_W'(64'sd2147483648);
        if (v > hi) return 32'sh7FFFFFFF;
        if (v < lo) return 32'sh80000000;
        return v[bspe_pkg::NB_W-1:0];
    endfunction

    function automatic logic [bspe_pkg::OUT_W-1:0] sat24(input logic signed [FULL_W-1:0] v);
        logic signed [FULL_W-1:0] hi;
        logic signed [FULL_W-1:0] lo;
        hi = FULL_W'(64'sd8388607);
        lo = -FULL_W'(64'sd8388608);
        if (v > hi) return 24'h7FFFFF;
        if (v < lo) return 24'h800000;
        return v[bspe_pkg::OUT_W-1:0];
    endfunction

    logic [bspe_pkg::KNOT_W-1:0]          knot_mem [bspe_pkg::KNOT_DEPTH];
    logic [2*bspe_pkg::PT_W-1:0]          point_mem [bspe_pkg::MAX_POINTS];
    logic [bspe_pkg::CFG_W-1:0]           pts_reg;
    logic [bspe_pkg::KNOT_W-1:0]          u_reg;
    logic [bspe_pkg::SPAN_W-1:0]          span_reg;
    logic signed [bspe_pkg::DIFF_W-1:0]   left_reg [1:3];
    logic signed [bspe_pkg::DIFF_W-1:0]   right_reg [1:3];
    logic signed [bspe_pkg::NB_W-1:0]     nb_reg [0:3];
    logic signed [SAV_W-1:0]              saved_reg;
    logic signed [bspe_pkg::TEMP_W-1:0]   temp_reg;
    logic signed [PROD_W-1:0]             ph_reg;
    logic signed [PROD_W-1:0]             pl_reg;
    logic signed [PP_W-1:0]               px_reg;
    logic signed [PP_W-1:0]               py_reg;
    logic signed [ACC_W-1:0]              sx_reg;
    logic signed [ACC_W-1:0]              sy_reg;
    logic                                 flag_reg;
    logic                                 ovalid_reg;
    logic [bspe_pkg::OUT_W-1:0]           ox_reg;
    logic [bspe_pkg::OUT_W-1:0]           oy_reg;
    logic [bspe_pkg::SPAN_W-1:0]          ospan_reg;
    logic                                 ostat_reg;

    logic [bspe_pkg::SPAN_W-1:0]          n_last;
    logic [bspe_pkg::IDX_W-1:0]           kaddr;
    logic [bspe_pkg::KNOT_W-1:0]          knot_rd;
    logic                                 u_ge;
    logic signed [bspe_pkg::DIFF_W-1:0]   diff_l;
    logic signed [bspe_pkg::DIFF_W-1:0]   diff_r;
    logic [1:0]                           ridx;
    logic [1:0]                           lidx;
    logic [1:0]                           nb_idx;
    logic signed [bspe_pkg::DIFF_W-1:0]   right_rd;
    logic signed [bspe_pkg::DIFF_W-1:0]   left_rd;
    logic signed [bspe_pkg::NB_W-1:0]     nb_rd;
    logic signed [bspe_pkg::DEN_W-1:0]    den;
    logic                                 den_zero;
    logic                                 div_start;
    logic                                 div_done;
    logic signed [bspe_pkg::QUO_W-1:0]    div_q;
    logic signed [bspe_pkg::TEMP_W-1:0]   temp_sat;
    logic signed [bspe_pkg::DIFF_W-1:0]   mul_a;
    logic signed [ML_W-1:0]               mul_b;
    logic signed [PROD_W-1:0]             mul_p;
    logic signed [FULL_W-1:0]             full;
    logic signed [FULL_W-1:0]             qtr;
    logic [bspe_pkg::SPAN_W-1:0]          paddr;
    logic [2*bspe_pkg::PT_W-1:0]          pt_rd;

    always_comb begin
        if (pts_reg < bspe_pkg::CFG_W'(bspe_pkg::DEGREE + 1)) begin
            n_last = bspe_pkg::SPAN_W'(bspe_pkg::DEGREE);
        end else if (pts_reg > bspe_pkg::CFG_W'(bspe_pkg::MAX_POINTS)) begin
            n_last = bspe_pkg::SPAN_W'(bspe_pkg::MAX_POINTS - 1);
        end else begin
            n_last = bspe_pkg::SPAN_W'(pts_reg - 1'b1);
        end
    end

    always_comb begin
        case (cmd.op)
            bspe_pkg::OP_SPAN_END:  kaddr = {1'b0, n_last} + 1'b1;
            bspe_pkg::OP_SPAN_SCAN: kaddr = {1'b0, cmd.k};
            bspe_pkg::OP_LEFT:      kaddr = {1'b0, span_reg} + 1'b1 - {3'b000, cmd.j};
            bspe_pkg::OP_RIGHT:     kaddr = {1'b0, span_reg} + {3'b000, cmd.j};
            default:                kaddr = '0;
        endcase
    end

    assign knot_rd = knot_mem[kaddr];
    assign u_ge    = u_reg >= knot_rd;
    assign diff_l  = $signed({1'b0, u_reg}) - $signed({1'b0, knot_rd});
    assign diff_r  = $signed({1'b0, knot_rd}) - $signed({1'b0, u_reg});

    assign ridx     = cmd.r + 1'b1;
    assign lidx     = cmd.j - cmd.r;
    assign nb_idx   = (cmd.op == bspe_pkg::OP_PT_MUL) ? cmd.k[1:0] : cmd.r;
    assign right_rd = right_reg[ridx];
    assign left_rd  = left_reg[lidx];
    assign nb_rd    = nb_reg[nb_idx];
    assign den      = {right_rd[bspe_pkg::DIFF_W-1], right_rd}
                    + {left_rd[bspe_pkg::DIFF_W-1], left_rd};
    assign den_zero = (den == '0);
    assign div_start = (cmd.op == bspe_pkg::OP_DIV_GO) && !den_zero;

    bspe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({nb_rd, 16'h0000}),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        if (div_q > TEMP_MAX) begin
            temp_sat = {1'b0, {(bspe_pkg::TEMP_W-1){1'b1}}};
        end else if (div_q < TEMP_MIN) begin
            temp_sat = {1'b1, {(bspe_pkg::TEMP_W-1){1'b0}}};
        end else begin
            temp_sat = div_q[bspe_pkg::TEMP_W-1:0];
        end
    end

    always_comb begin
        if (cmd.op == bspe_pkg::OP_LMH || cmd.op == bspe_pkg::OP_LML) begin
            mul_a = left_rd;
        end else begin
            mul_a = right_rd;
        end
        if (cmd.op == bspe_pkg::OP_RMH || cmd.op == bspe_pkg::OP_LMH) begin
            mul_b = ML_W'($signed(temp_reg[bspe_pkg::TEMP_W-1:TEMP_LO_W]));
        end else begin
            mul_b = $signed({1'b0, temp_reg[TEMP_LO_W-1:0]});
        end
    end

    assign mul_p = mul_a * mul_b;
    assign full  = (FULL_W'(ph_reg) <<< TEMP_LO_W) + FULL_W'(pl_reg);
    assign qtr   = trunc16(full);
    assign paddr = span_reg - bspe_pkg::SPAN_W'(bspe_pkg::DEGREE) + cmd.k;
    assign pt_rd = point_mem[paddr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pts_reg    <= bspe_pkg::CFG_W'(bspe_pkg::DEGREE + 1);
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pts_reg <= cfg_wr_data;
            end
            if (cmd.op == bspe_pkg::OP_FINISH) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end

        if (div_done) begin
            temp_reg <= temp_sat;
        end

        case (cmd.op)
            bspe_pkg::OP_LOAD: begin
                if (in_mode == bspe_pkg::MODE_KNOT
                    && in_index < bspe_pkg::IDX_W'(bspe_pkg::KNOT_DEPTH)) begin
                    knot_mem[in_index] <= in_knot_value;
                end
                if (in_mode == bspe_pkg::MODE_POINT
                    && in_index < bspe_pkg::IDX_W'(bspe_pkg::MAX_POINTS)) begin
                    point_mem[in_index[bspe_pkg::SPAN_W-1:0]] <= {in_point_y, in_point_x};
                end
                if (in_mode == bspe_pkg::MODE_EVAL) begin
                    u_reg <= in_param_u;
                end
            end
            bspe_pkg::OP_SPAN_END: begin
                span_reg <= u_ge ? n_last : bspe_pkg::SPAN_W'(bspe_pkg::DEGREE);
            end
            bspe_pkg::OP_SPAN_SCAN: begin
                if (u_ge) begin
                    span_reg <= cmd.k;
                end
            end
            bspe_pkg::OP_INIT: begin
                nb_reg[0] <= 32'sh01000000;
                sx_reg    <= '0;
                sy_reg    <= '0;
                flag_reg  <= 1'b0;
            end
            bspe_pkg::OP_LEFT: begin
                left_reg[cmd.j] <= diff_l;
                saved_reg       <= '0;
            end
            bspe_pkg::OP_RIGHT: begin
                right_reg[cmd.j] <= diff_r;
            end
            bspe_pkg::OP_DIV_GO: begin
                if (den_zero) begin
                    temp_reg <= '0;
                    flag_reg <= 1'b1;
                end
            end
            bspe_pkg::OP_RMH, bspe_pkg::OP_LMH: begin
                ph_reg <= mul_p;
            end
            bspe_pkg::OP_RML, bspe_pkg::OP_LML: begin
                pl_reg <= mul_p;
            end
            bspe_pkg::OP_RFIN: begin
                nb_reg[cmd.r] <= sat32(FULL_W'(saved_reg) + qtr);
            end
            bspe_pkg::OP_LFIN: begin
                saved_reg <= qtr[SAV_W-1:0];
            end
            bspe_pkg::OP_NBJ: begin
                nb_reg[cmd.j] <= sat32(FULL_W'(saved_reg));
            end
            bspe_pkg::OP_PT_MUL: begin
                px_reg <= nb_rd * $signed(pt_rd[bspe_pkg::PT_W-1:0]);
                py_reg <= nb_rd * $signed(pt_rd[2*bspe_pkg::PT_W-1:bspe_pkg::PT_W]);
            end
            bspe_pkg::OP_PT_ACC: begin
                sx_reg <= sx_reg + ACC_W'(px_reg);
                sy_reg <= sy_reg + ACC_W'(py_reg);
            end
            bspe_pkg::OP_FINISH: begin
                ox_reg    <= sat24(trunc16(FULL_W'(sx_reg)));
                oy_reg    <= sat24(trunc16(FULL_W'(sy_reg)));
                ospan_reg <= span_reg;
                ostat_reg <= flag_reg;
            end
            default: begin
            end
        endcase
    end

    assign stat.u_ge_knot = u_ge;
    assign stat.den_zero  = den_zero;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !ovalid_reg || out_ready;
    assign stat.n_last    = n_last;

    assign out_valid   = ovalid_reg;
    assign out_curve_x = ox_reg;
    assign out_curve_y = oy_reg;
    assign out_span    = ospan_reg;
    assign out_status  = ostat_reg;

endmodule
`default_nettype wire

// File: rtl/bspe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspe_ctrl
// Sequencer: span search, basis triangle over j and r, point sum and
// result handoff.
// ----------------------------------------------------------------------------
module bspe_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [bspe_pkg::MODE_W-1:0]   in_mode,
    output logic                               in_ready,
    output bspe_pkg::dp_cmd_t                  cmd,
    input  wire bspe_pkg::dp_stat_t            stat
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SPAN_END  = 5'd1;
    localparam logic [4:0] S_SPAN_SCAN = 5'd2;
    localparam logic [4:0] S_INIT      = 5'd3;
    localparam logic [4:0] S_LEFT      = 5'd4;
    localparam logic [4:0] S_RIGHT     = 5'd5;
    localparam logic [4:0] S_DIV_GO    = 5'd6;
    localparam logic [4:0] S_DIV_WAIT  = 5'd7;
    localparam logic [4:0] S_RMH       = 5'd8;
    localparam logic [4:0] S_RML       = 5'd9;
    localparam logic [4:0] S_RFIN      = 5'd10;
    localparam logic [4:0] S_LMH       = 5'd11;
    localparam logic [4:0] S_LML       = 5'd12;
    localparam logic [4:0] S_LFIN      = 5'd13;
    localparam logic [4:0] S_NBJ       = 5'd14;
    localparam logic [4:0] S_PMUL      = 5'd15;
    localparam logic [4:0] S_PACC      = 5'd16;
    localparam logic [4:0] S_DONE      = 5'd17;

    logic [4:0]                  state_reg, state_next;
    logic [1:0]                  j_reg, j_next;
    logic [1:0]                  r_reg, r_next;
    logic [bspe_pkg::SPAN_W-1:0] k_reg, k_next;

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        cmd.op     = bspe_pkg::OP_NONE;
        cmd.j      = j_reg;
        cmd.r      = r_reg;
        cmd.k      = k_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op = bspe_pkg::OP_LOAD;
                    if (in_mode == bspe_pkg::MODE_EVAL) begin
                        state_next = S_SPAN_END;
                    end
                end
            end
            S_SPAN_END: begin
                cmd.op = bspe_pkg::OP_SPAN_END;
                if (stat.u_ge_knot
                    || stat.n_last == bspe_pkg::SPAN_W'(bspe_pkg::DEGREE)) begin
                    state_next = S_INIT;
                end else begin
                    k_next     = bspe_pkg::SPAN_W'(bspe_pkg::DEGREE + 1);
                    state_next = S_SPAN_SCAN;
                end
            end
            S_SPAN_SCAN: begin
                cmd.op = bspe_pkg::OP_SPAN_SCAN;
                if (k_reg == stat.n_last) begin
                    state_next = S_INIT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_INIT: begin
                cmd.op     = bspe_pkg::OP_INIT;
                j_next     = 2'd1;
                state_next = S_LEFT;
            end
            S_LEFT: begin
                cmd.op     = bspe_pkg::OP_LEFT;
                state_next = S_RIGHT;
            end
            S_RIGHT: begin
                cmd.op     = bspe_pkg::OP_RIGHT;
                r_next     = 2'd0;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.op     = bspe_pkg::OP_DIV_GO;
                state_next = stat.den_zero ? S_RMH : S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_RMH;
                end
            end
            S_RMH: begin
                cmd.op     = bspe_pkg::OP_RMH;
                state_next = S_RML;
            end
            S_RML: begin
                cmd.op     = bspe_pkg::OP_RML;
                state_next = S_RFIN;
            end
            S_RFIN: begin
                cmd.op     = bspe_pkg::OP_RFIN;
                state_next = S_LMH;
            end
            S_LMH: begin
                cmd.op     = bspe_pkg::OP_LMH;
                state_next = S_LML;
            end
            S_LML: begin
                cmd.op     = bspe_pkg::OP_LML;
                state_next = S_LFIN;
            end
            S_LFIN: begin
                cmd.op = bspe_pkg::OP_LFIN;
                if (r_reg == j_reg - 1'b1) begin
                    state_next = S_NBJ;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_DIV_GO;
                end
            end
            S_NBJ: begin
                cmd.op = bspe_pkg::OP_NBJ;
                if (j_reg == 2'(bspe_pkg::DEGREE)) begin
                    k_next     = '0;
                    state_next = S_PMUL;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_LEFT;
                end
            end
            S_PMUL: begin
                cmd.op     = bspe_pkg::OP_PT_MUL;
                state_next = S_PACC;
            end
            S_PACC: begin
                cmd.op = bspe_pkg::OP_PT_ACC;
                if (k_reg == bspe_pkg::SPAN_W'(bspe_pkg::DEGREE)) begin
                    state_next = S_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_PMUL;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = bspe_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            r_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// File: rtl/cubic_bspline_point_evaluator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_point_evaluator_core
// Cubic B-spline curve point evaluator with knot and control point stores.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests; s_tuser selects knot write, point write or
//   evaluate. Writes produce nothing on m_.
//   An evaluate request produces one result on m_: curve point in Q16.8,
//   span and a status bit set when a zero basis denominator was met.
//   An evaluation runs the span search, scanning up to 12 knots, then 6
//   divisions; a zero denominator skips its division. All divisions go
//   through the one bit-serial divider. Requests are taken one at a time;
//   the next one is accepted once the result is registered.
//   The finished result sits in an output register; the next request is
//   accepted while it waits, and a stalled m_tready holds only the end of
//   the following evaluation.
//   points_in_use is written through cfg_wr_en/cfg_wr_data; the user must
//   do so only while idle, the core itself does not enforce this.
//   Reset sets points_in_use to 4 and clears the handshake state; knot and
//   point contents are undefined until written.
// ----------------------------------------------------------------------------
module cubic_bspline_point_evaluator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // index[4:0], knot_value[21:5], point_x[37:22], point_y[53:38],
    // param_u[70:54], zero[71]
    input  wire logic [71:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // curve_x[23:0], curve_y[47:24], span_index[51:48], zero[55:52]
    output logic [55:0]      m_tdata,
    // status[0]
    output logic [0:0]       m_tuser
);

    bspe_pkg::dp_cmd_t  cmd;
    bspe_pkg::dp_stat_t stat;
    logic [bspe_pkg::OUT_W-1:0]  cx;
    logic [bspe_pkg::OUT_W-1:0]  cy;
    logic [bspe_pkg::SPAN_W-1:0] sp;
    logic                        st;

    bspe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bspe_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_mode       (s_tuser),
        .in_index      (s_tdata[4:0]),
        .in_knot_value (s_tdata[21:5]),
        .in_point_x    (s_tdata[37:22]),
        .in_point_y    (s_tdata[53:38]),
        .in_param_u    (s_tdata[70:54]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_curve_x   (cx),
        .out_curve_y   (cy),
        .out_span      (sp),
        .out_status    (st)
    );

    assign m_tdata = {4'h0, sp, cy, cx};
    assign m_tuser = st;

endmodule
`default_nettype wire
